// File: rtl/core/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the button debounce / auto-repeat core.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int MS_W      = 32;
    localparam int CFG_W     = 16;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_PRESS  = 3'd1,
        KIND_REPEAT = 3'd2,
        KIND_FLUSH  = 3'd3,
        KIND_INIT   = 3'd4
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] DELAY_RST    = 16'd400;
    localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd140;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [KIND_W-1:0] kind;
        logic              sel;
        logic              lv;
    } t_cell_cmd;

    typedef struct packed {
        logic            down;
        logic            ev;
        logic [MS_W-1:0] held;
    } t_cell_stat;

endpackage

// File: rtl/core/bda_cell.sv
// ----------------------------------------------------------------------------
// bda_cell
// Per-button debounce, press latch, ignore and auto-repeat state.
// ----------------------------------------------------------------------------
module bda_cell
    import bda_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  t_cell_cmd       i_cmd,
    input  logic [MS_W-1:0] i_now_n,
    output t_cell_stat      o_stat
);

    logic            r_raw,    n_raw;
    logic            r_stable, n_stable;
    logic            r_pend,   n_pend;
    logic            r_ign,    n_ign;
    logic [MS_W-1:0] r_chg,    n_chg;
    logic [MS_W-1:0] r_prs,    n_prs;
    logic [MS_W-1:0] r_due,    n_due;
    logic            ev;
    logic [MS_W-1:0] since_chg;
    logic [MS_W-1:0] since_due;

    assign since_chg = i_now_n - r_chg;
    assign since_due = i_now_n - r_due;

    always_comb begin
        n_raw    = r_raw;
        n_stable = r_stable;
        n_pend   = r_pend;
        n_ign    = r_ign;
        n_chg    = r_chg;
        n_prs    = r_prs;
        n_due    = r_due;
        ev       = 1'b0;
        if (i_cmd.en) begin
            case (i_cmd.kind)
                KIND_TICK: begin
                    if (i_cmd.lv != r_raw) begin
                        n_raw = i_cmd.lv;
                        n_chg = i_now_n;
                    end else if (i_cmd.lv != r_stable &&
                                 since_chg >= MS_W'(i_cfg.debounce)) begin
                        n_stable = i_cmd.lv;
                        if (i_cmd.lv) begin
                            n_prs  = i_now_n;
                            n_due  = i_now_n + MS_W'(i_cfg.delay);
                            n_pend = ~r_ign;
                        end else begin
                            n_ign = 1'b0;
                        end
                    end
                end
                KIND_PRESS: begin
                    if (i_cmd.sel) begin
                        ev     = r_pend;
                        n_pend = 1'b0;
                    end
                end
                KIND_REPEAT: begin
                    if (i_cmd.sel) begin
                        if (r_pend) begin
                            ev     = 1'b1;
                            n_pend = 1'b0;
                        end else if (r_stable && !r_ign && !since_due[MS_W-1]) begin
                            ev    = 1'b1;
                            n_due = i_now_n + MS_W'(i_cfg.period);
                        end
                    end
                end
                KIND_FLUSH: begin
                    n_pend = 1'b0;
                    n_ign  = r_stable;
                end
                KIND_INIT: begin
                    n_raw    = i_cmd.lv;
                    n_stable = i_cmd.lv;
                    n_ign    = 1'b0;
                    n_chg    = i_now_n;
                    n_prs    = i_now_n;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.down = n_stable & ~n_ign;
        o_stat.ev   = ev;
        o_stat.held = (o_stat.down && i_cmd.sel) ? (i_now_n - n_prs) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= 1'b0;
            r_stable <= 1'b0;
            r_pend   <= 1'b0;
            r_ign    <= 1'b0;
            r_chg    <= '0;
            r_prs    <= '0;
            r_due    <= '0;
        end else begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
            r_pend   <= n_pend;
            r_ign    <= n_ign;
            r_chg    <= n_chg;
            r_prs    <= n_prs;
            r_due    <= n_due;
        end
    end

endmodule

// File: rtl/core/button_debounce_autorepeat_core.sv
// Each input transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle unless the result side stalls; per-button
// update is one registered pass between the input register and the result register.
// Reset (i_rst_n low, synchronous): time counter and all button state
// cleared, registers back to 20 / 400 / 140 ms, both sides empty.
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_core
// Debounces NUM_BUTTONS button levels and answers press / repeat queries.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_core
    import bda_pkg::*;
#(
    parameter int NUM_BUTTONS = 3,
    localparam int BTN_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
    localparam int IN_RAW  = BTN_W + NUM_BUTTONS,
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = 1 + NUM_BUTTONS + 1 + MS_W,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_W-1:0]      i_s_axis_tdata,  // button, levels, zero pad
    input  logic [KIND_W-1:0]    i_s_axis_tuser,  // kind
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata   // event_flag, down_mask, any_down,
                                                  // held_ms, zero pad
);

    t_cfg                   r_cfg;
    logic                   r_in_vld;
    logic [KIND_W-1:0]      r_kind;
    logic [BTN_W-1:0]       r_btn;
    logic [NUM_BUTTONS-1:0] r_lv;
    logic                   r_out_vld;
    logic [OUT_RAW-1:0]     r_out;
    logic [MS_W-1:0]        r_now, n_now;

    logic                   s_fire;
    logic                   out_free;
    logic                   advance;
    t_cell_stat             stat [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] down_mask;
    logic [NUM_BUTTONS-1:0] ev_vec;
    logic                   ev;
    logic [MS_W-1:0]        held;

    assign o_cfg_ready     = 1'b1;
    assign out_free        = ~r_out_vld | i_m_axis_tready;
    assign o_s_axis_tready = ~r_in_vld | out_free;
    assign s_fire          = i_s_axis_tvalid & o_s_axis_tready;
    assign advance         = r_in_vld & out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= DEBOUNCE_RST;
            r_cfg.delay    <= DELAY_RST;
            r_cfg.period   <= PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_data;
                CFG_DELAY:    r_cfg.delay    <= i_cfg_data;
                CFG_PERIOD:   r_cfg.period   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= s_fire | (r_in_vld & ~out_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_kind <= i_s_axis_tuser;
            r_btn  <= i_s_axis_tdata[BTN_W-1:0];
            r_lv   <= i_s_axis_tdata[IN_RAW-1:BTN_W];
        end
    end

    assign n_now = (advance && r_kind == KIND_TICK) ? r_now + MS_W'(1) : r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
        end else begin
            r_now <= n_now;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        t_cell_cmd cmd;
        always_comb begin
            cmd.en   = advance;
            cmd.kind = r_kind;
            cmd.sel  = (r_btn == BTN_W'(g));
            cmd.lv   = r_lv[g];
        end
        bda_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_cmd   (cmd),
            .i_now_n (n_now),
            .o_stat  (stat[g])
        );
        assign down_mask[g] = stat[g].down;
        assign ev_vec[g]    = stat[g].ev;
    end

    assign ev = |ev_vec;

    always_comb begin
        held = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            held = held | stat[i].held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= {held, |down_mask, down_mask, ev};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_out);

    a_no_event_on_other_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_kind != KIND_PRESS && r_kind != KIND_REPEAT) |=> !r_out[0])
        else $error("event flag set for a transaction that is not a query");

    a_tick_advances_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_kind == KIND_TICK) |=> (r_now == $past(r_now) + MS_W'(1)))
        else $error("time counter did not advance on tick");

    a_time_holds_otherwise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && r_kind == KIND_TICK) |=> $stable(r_now))
        else $error("time counter moved without a tick");

    a_in_reg_held_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_free) |=> (r_in_vld && $stable(r_kind) && $stable(r_btn)
                                     && $stable(r_lv)))
        else $error("pending input transaction lost while result side stalled");

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule
